// ===== rtl/sva_pkg.sv =====
`timescale 1ns / 1ps
// Package for the synth voice allocator: command codes, sequencer states,
// voice record layout and the key-to-frequency table. No dependencies.

package sva_pkg;

    typedef enum logic [1:0] {
        CMD_NOTE_OFF   = 2'd0,
        CMD_NOTE_ON    = 2'd1,
        CMD_AFTERTOUCH = 2'd2,
        CMD_PROGRAM    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DONE
    } t_state;

    // what the voice memory keeps for a busy voice
    typedef struct packed {
        logic [3:0] channel;
        logic [5:0] track;
        logic [6:0] key;
    } t_voice;

    localparam int          TRACKS       = 64;
    localparam logic [3:0]  DRUM_CHANNEL = 4'd9;
    localparam logic [6:0]  PERC_LO_MIN  = 7'd8;
    localparam logic [6:0]  PERC_LO_MAX  = 7'd15;
    localparam logic [6:0]  PERC_HI_MIN  = 7'd112;
    localparam logic [6:0]  PERC_HI_MAX  = 7'd119;

    // key frequency in Hz, unsigned 14.16
    localparam logic [29:0] KEY_FREQ [128] = '{
        30'h00082d01, 30'h0008a976, 30'h00092d51, 30'h0009b904,
        30'h000a4d05, 30'h000ae9d3, 30'h000b8ff4, 30'h000c3ff6,
        30'h000cfa70, 30'h000dc000, 30'h000e914f, 30'h000f6f11,
        30'h00105a02, 30'h001152ec, 30'h00125aa2, 30'h00137208,
        30'h00149a0a, 30'h0015d3a6, 30'h00171fe9, 30'h00187fed,
        30'h0019f4e0, 30'h001b8000, 30'h001d229e, 30'h001ede22,
        30'h0020b404, 30'h0022a5d8, 30'h0024b545, 30'h0026e410,
        30'h00293414, 30'h002ba74d, 30'h002e3fd2, 30'h0030ffda,
        30'h0033e9c0, 30'h00370000, 30'h003a453d, 30'h003dbc44,
        30'h00416809, 30'h00454bb0, 30'h00496a8b, 30'h004dc820,
        30'h00526829, 30'h00574e9b, 30'h005c7fa4, 30'h0061ffb5,
        30'h0067d380, 30'h006e0000, 30'h00748a7b, 30'h007b7888,
        30'h0082d012, 30'h008a9760, 30'h0092d517, 30'h009b9041,
        30'h00a4d053, 30'h00ae9d36, 30'h00b8ff49, 30'h00c3ff6a,
        30'h00cfa700, 30'h00dc0000, 30'h00e914f6, 30'h00f6f110,
        30'h0105a025, 30'h01152ec0, 30'h0125aa2e, 30'h01372082,
        30'h0149a0a7, 30'h015d3a6d, 30'h0171fe92, 30'h0187fed4,
        30'h019f4e00, 30'h01b80000, 30'h01d229ec, 30'h01ede220,
        30'h020b404a, 30'h022a5d81, 30'h024b545c, 30'h026e4104,
        30'h0293414f, 30'h02ba74da, 30'h02e3fd24, 30'h030ffda9,
        30'h033e9c01, 30'h03700000, 30'h03a453d8, 30'h03dbc440,
        30'h04168094, 30'h0454bb03, 30'h0496a8b8, 30'h04dc8208,
        30'h0526829e, 30'h0574e9b5, 30'h05c7fa49, 30'h061ffb53,
        30'h067d3802, 30'h06e00000, 30'h0748a7b1, 30'h07b78880,
        30'h082d0128, 30'h08a97607, 30'h092d5171, 30'h09b90410,
        30'h0a4d053c, 30'h0ae9d36b, 30'h0b8ff493, 30'h0c3ff6a7,
        30'h0cfa7005, 30'h0dc00000, 30'h0e914f62, 30'h0f6f1100,
        30'h105a0250, 30'h1152ec0e, 30'h125aa2e3, 30'h13720820,
        30'h149a0a79, 30'h15d3a6d6, 30'h171fe927, 30'h187fed4e,
        30'h19f4e00a, 30'h1b800000, 30'h1d229ec4, 30'h1ede2200,
        30'h20b404a1, 30'h22a5d81c, 30'h24b545c7, 30'h26e41040,
        30'h293414f2, 30'h2ba74dac, 30'h2e3fd24f, 30'h30ffda9c
    };

endpackage

// ===== rtl/synth_voice_allocator.sv =====
`timescale 1ns / 1ps
// Voice allocator top level: sequencer, voice memory, channel program table
// and output register. Uses sva_pkg.

// Maps MIDI note events onto VOICES synthesizer voices and emits at most one
// word per event (voice, key-on bit, 14.16 key frequency, velocity >> 3).
// A note off, note on or aftertouch is scanned: the voice records sit in a
// memory with one registered read port, and a single compare unit checks one
// record per cycle for a matching note, the lowest free voice and the lowest
// busy voice of the same channel, after which the DONE state commits the
// choice. Program changes, note ons on the drum channel or with a percussion
// program, and notes with an out-of-range track are absorbed in the cycle
// they are taken. A result waits in the output register while the next word
// is already accepted; the input stalls whenever the sequencer is not idle:
// while an event is scanned, committed, or its result cannot yet be loaded.
// Reset frees all voices and clears the channel program table at once.

module synth_voice_allocator #(
    parameter int VOICES = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_channel_number,
    input  logic [5:0]  i_track_number,
    input  logic [6:0]  i_note_key,
    input  logic [6:0]  i_level_value,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_voice_index,
    output logic        o_key_on,
    output logic [29:0] o_frequency_word,
    output logic [3:0]  o_envelope_level
);

    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;

    sva_pkg::t_state    r_state, n_state;

    // event being worked on
    sva_pkg::t_cmd      r_cmd;
    logic [3:0]         r_ch;
    logic [5:0]         r_trk;
    logic [6:0]         r_key;
    logic [6:0]         r_vel;

    // voice state
    logic [VOICES-1:0]  r_busy;
    sva_pkg::t_voice    r_mem [VOICES];
    logic [6:0]         r_prog [16];

    // scan pipeline
    logic [IW-1:0]      r_cnt;
    sva_pkg::t_voice    r_rd_data;
    logic [IW-1:0]      r_rd_idx;
    logic               r_rd_vld;

    logic               r_m_hit, r_f_hit, r_s_hit;
    logic [IW-1:0]      r_m_idx, r_f_idx, r_s_idx;

    // output register
    logic               r_out_valid;
    logic [3:0]         r_out_voice;
    logic               r_out_key_on;
    logic [29:0]        r_out_freq;
    logic [3:0]         r_out_level;

    logic               take;
    logic               start_scan;
    logic               out_free;
    logic               emit;
    logic               sel_hit;
    logic [IW-1:0]      sel_idx;
    sva_pkg::t_cmd      eff_cmd;
    logic               track_bad;
    logic               drum;
    logic [6:0]         prog_rd;
    logic               rd_busy;
    logic               same_ch;
    logic               match;

    assign take     = i_in_valid && (r_state == sva_pkg::ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // decode of the incoming word
    always_comb begin
        eff_cmd = sva_pkg::t_cmd'(i_command);
        if (eff_cmd == sva_pkg::CMD_NOTE_ON && i_level_value == 7'd0) begin
            eff_cmd = sva_pkg::CMD_NOTE_OFF;
        end
        prog_rd   = r_prog[i_channel_number];
        track_bad = {1'b0, i_track_number} >= 7'(sva_pkg::TRACKS);
        drum      = (i_channel_number == sva_pkg::DRUM_CHANNEL)
                 || (prog_rd >= sva_pkg::PERC_LO_MIN && prog_rd <= sva_pkg::PERC_LO_MAX)
                 || (prog_rd >= sva_pkg::PERC_HI_MIN && prog_rd <= sva_pkg::PERC_HI_MAX);
        start_scan = take && eff_cmd != sva_pkg::CMD_PROGRAM && !track_bad
                  && !(eff_cmd == sva_pkg::CMD_NOTE_ON && drum);
    end

    // shared compare unit: one voice record per cycle
    always_comb begin
        rd_busy = r_busy[r_rd_idx];
        same_ch = rd_busy && (r_rd_data.channel == r_ch);
        match   = same_ch && (r_rd_data.track == r_trk) && (r_rd_data.key == r_key);
    end

    // commit choice: match, else free, else steal (note on only)
    always_comb begin
        sel_idx = r_m_idx;
        sel_hit = r_m_hit;
        if (r_cmd == sva_pkg::CMD_NOTE_ON && !r_m_hit) begin
            priority if (r_f_hit) begin
                sel_idx = r_f_idx;
                sel_hit = 1'b1;
            end else if (r_s_hit) begin
                sel_idx = r_s_idx;
                sel_hit = 1'b1;
            end else begin
                sel_hit = 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        emit    = 1'b0;
        unique case (r_state)
            sva_pkg::ST_IDLE: begin
                if (start_scan) begin
                    n_state = sva_pkg::ST_SCAN;
                end
            end
            sva_pkg::ST_SCAN: begin
                if (r_cnt == IW'(VOICES - 1)) begin
                    n_state = sva_pkg::ST_LAST;
                end
            end
            sva_pkg::ST_LAST: begin
                n_state = sva_pkg::ST_DONE;
            end
            sva_pkg::ST_DONE: begin
                if (!sel_hit) begin
                    n_state = sva_pkg::ST_IDLE;
                end else if (out_free) begin
                    emit    = 1'b1;
                    n_state = sva_pkg::ST_IDLE;
                end
            end
            default: n_state = sva_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sva_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // captured word, scan counter, hit flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_m_hit  <= 1'b0;
            r_f_hit  <= 1'b0;
            r_s_hit  <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == sva_pkg::ST_SCAN);
            if (take) begin
                r_cmd   <= eff_cmd;
                r_ch    <= i_channel_number;
                r_trk   <= i_track_number;
                r_key   <= i_note_key;
                r_vel   <= i_level_value;
                r_cnt   <= '0;
                r_m_hit <= 1'b0;
                r_f_hit <= 1'b0;
                r_s_hit <= 1'b0;
            end
            if (r_state == sva_pkg::ST_SCAN) begin
                r_cnt <= r_cnt + IW'(1);
            end
            if (r_rd_vld) begin
                if (match && !r_m_hit) begin
                    r_m_hit <= 1'b1;
                    r_m_idx <= r_rd_idx;
                end
                if (!rd_busy && !r_f_hit) begin
                    r_f_hit <= 1'b1;
                    r_f_idx <= r_rd_idx;
                end
                if (same_ch && !r_s_hit) begin
                    r_s_hit <= 1'b1;
                    r_s_idx <= r_rd_idx;
                end
            end
        end
    end

    // voice memory, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == sva_pkg::ST_SCAN) begin
            r_rd_data <= r_mem[r_cnt];
            r_rd_idx  <= r_cnt;
        end
        if (emit && r_cmd == sva_pkg::CMD_NOTE_ON) begin
            r_mem[sel_idx] <= '{channel: r_ch, track: r_trk, key: r_key};
        end
    end

    // busy marks and channel programs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
            for (int c = 0; c < 16; c++) begin
                r_prog[c] <= '0;
            end
        end else begin
            if (take && eff_cmd == sva_pkg::CMD_PROGRAM) begin
                r_prog[i_channel_number] <= i_level_value;
            end
            if (emit) begin
                r_busy[sel_idx] <= (r_cmd != sva_pkg::CMD_NOTE_OFF);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (emit) begin
            r_out_voice  <= 4'(sel_idx);
            r_out_key_on <= (r_cmd != sva_pkg::CMD_NOTE_OFF);
            r_out_freq   <= sva_pkg::KEY_FREQ[r_key];
            r_out_level  <= r_vel[6:3];
        end
    end

    assign o_in_stall       = (r_state != sva_pkg::ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_voice_index    = r_out_voice;
    assign o_key_on         = r_out_key_on;
    assign o_frequency_word = r_out_freq;
    assign o_envelope_level = r_out_level;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for synth_voice_allocator: queued MIDI events, a voice
// allocation predictor and a result word checker. Depends on sva_pkg and the RTL.

module tb_top;

    localparam int VOICES   = 9;
    localparam int LIMIT    = 600000;
    localparam int N_RANDOM = 1080;
    localparam int TAIL     = 40;

    typedef struct packed {
        sva_pkg::t_cmd cmd;
        logic [3:0]    chan;
        logic [5:0]    trk;
        logic [6:0]    key;
        logic [6:0]    lvl;
    } t_midi_event;

    typedef struct packed {
        logic [3:0]  voice;
        logic        key_on;
        logic [29:0] freq;
        logic [3:0]  level;
    } t_note_word;

    // key frequency, Hz in 14.16
    localparam logic [29:0] NOTE_HZ [128] = '{
        30'h00082d01, 30'h0008a976, 30'h00092d51, 30'h0009b904,
        30'h000a4d05, 30'h000ae9d3, 30'h000b8ff4, 30'h000c3ff6,
        30'h000cfa70, 30'h000dc000, 30'h000e914f, 30'h000f6f11,
        30'h00105a02, 30'h001152ec, 30'h00125aa2, 30'h00137208,
        30'h00149a0a, 30'h0015d3a6, 30'h00171fe9, 30'h00187fed,
        30'h0019f4e0, 30'h001b8000, 30'h001d229e, 30'h001ede22,
        30'h0020b404, 30'h0022a5d8, 30'h0024b545, 30'h0026e410,
        30'h00293414, 30'h002ba74d, 30'h002e3fd2, 30'h0030ffda,
        30'h0033e9c0, 30'h00370000, 30'h003a453d, 30'h003dbc44,
        30'h00416809, 30'h00454bb0, 30'h00496a8b, 30'h004dc820,
        30'h00526829, 30'h00574e9b, 30'h005c7fa4, 30'h0061ffb5,
        30'h0067d380, 30'h006e0000, 30'h00748a7b, 30'h007b7888,
        30'h0082d012, 30'h008a9760, 30'h0092d517, 30'h009b9041,
        30'h00a4d053, 30'h00ae9d36, 30'h00b8ff49, 30'h00c3ff6a,
        30'h00cfa700, 30'h00dc0000, 30'h00e914f6, 30'h00f6f110,
        30'h0105a025, 30'h01152ec0, 30'h0125aa2e, 30'h01372082,
        30'h0149a0a7, 30'h015d3a6d, 30'h0171fe92, 30'h0187fed4,
        30'h019f4e00, 30'h01b80000, 30'h01d229ec, 30'h01ede220,
        30'h020b404a, 30'h022a5d81, 30'h024b545c, 30'h026e4104,
        30'h0293414f, 30'h02ba74da, 30'h02e3fd24, 30'h030ffda9,
        30'h033e9c01, 30'h03700000, 30'h03a453d8, 30'h03dbc440,
        30'h04168094, 30'h0454bb03, 30'h0496a8b8, 30'h04dc8208,
        30'h0526829e, 30'h0574e9b5, 30'h05c7fa49, 30'h061ffb53,
        30'h067d3802, 30'h06e00000, 30'h0748a7b1, 30'h07b78880,
        30'h082d0128, 30'h08a97607, 30'h092d5171, 30'h09b90410,
        30'h0a4d053c, 30'h0ae9d36b, 30'h0b8ff493, 30'h0c3ff6a7,
        30'h0cfa7005, 30'h0dc00000, 30'h0e914f62, 30'h0f6f1100,
        30'h105a0250, 30'h1152ec0e, 30'h125aa2e3, 30'h13720820,
        30'h149a0a79, 30'h15d3a6d6, 30'h171fe927, 30'h187fed4e,
        30'h19f4e00a, 30'h1b800000, 30'h1d229ec4, 30'h1ede2200,
        30'h20b404a1, 30'h22a5d81c, 30'h24b545c7, 30'h26e41040,
        30'h293414f2, 30'h2ba74dac, 30'h2e3fd24f, 30'h30ffda9c
    };

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        out_stall = 1'b0;
    t_midi_event drv_ev    = '0;

    wire         in_stall;
    wire         out_valid;
    wire  [3:0]  voice_index;
    wire         key_on;
    wire  [29:0] frequency_word;
    wire  [3:0]  envelope_level;

    // voice table as the allocator should hold it
    logic       vc_busy [VOICES] = '{default: 1'b0};
    logic [6:0] vc_key  [VOICES] = '{default: '0};
    logic [6:0] vc_vel  [VOICES] = '{default: '0};
    logic [5:0] vc_trk  [VOICES] = '{default: '0};
    logic [3:0] vc_chan [VOICES] = '{default: '0};
    logic [6:0] chan_prog [16]   = '{default: '0};

    t_midi_event event_queue [$];
    t_note_word  pending_words [$];

    int n_sent      = 0;
    int n_accepted  = 0;
    int gap_left    = 0;
    int n_words     = 0;
    int n_key_on    = 0;
    int n_steals    = 0;
    int n_dropped   = 0;
    int n_skipped   = 0;
    int n_err       = 0;
    int cycle_count = 0;

    synth_voice_allocator #(
        .VOICES (VOICES)
    ) u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_command        (drv_ev.cmd),
        .i_channel_number (drv_ev.chan),
        .i_track_number   (drv_ev.trk),
        .i_note_key       (drv_ev.key),
        .i_level_value    (drv_ev.lvl),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_voice_index    (voice_index),
        .o_key_on         (key_on),
        .o_frequency_word (frequency_word),
        .o_envelope_level (envelope_level)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_perc_program(logic [6:0] p);
        return (p >= sva_pkg::PERC_LO_MIN && p <= sva_pkg::PERC_LO_MAX)
            || (p >= sva_pkg::PERC_HI_MIN && p <= sva_pkg::PERC_HI_MAX);
    endfunction

    // Updates the voice table for one event; returns 1 with the word it causes.
    function automatic bit allocate_voice(input t_midi_event ev, output t_note_word w);
        int            hit;
        int            i;
        sva_pkg::t_cmd op;
        hit = -1;
        op  = ev.cmd;
        w   = '0;
        if (op == sva_pkg::CMD_PROGRAM) begin
            chan_prog[ev.chan] = ev.lvl;
            return 0;
        end
        if (op == sva_pkg::CMD_NOTE_ON && ev.lvl == 7'd0)
            op = sva_pkg::CMD_NOTE_OFF;
        for (i = VOICES - 1; i >= 0; i--)
            if (vc_busy[i] && vc_chan[i] == ev.chan && vc_trk[i] == ev.trk
                && vc_key[i] == ev.key)
                hit = i;
        if (op == sva_pkg::CMD_NOTE_OFF) begin
            if (hit < 0)
                return 0;
            vc_busy[hit] = 1'b0;
        end else if (op == sva_pkg::CMD_AFTERTOUCH) begin
            if (hit < 0)
                return 0;
            vc_vel[hit] = ev.lvl;
        end else begin
            if (ev.chan == sva_pkg::DRUM_CHANNEL || is_perc_program(chan_prog[ev.chan])) begin
                n_skipped++;
                return 0;
            end
            if (hit < 0)
                for (i = VOICES - 1; i >= 0; i--)
                    if (!vc_busy[i])
                        hit = i;
            // all voices busy: take over the lowest one playing this channel
            if (hit < 0) begin
                for (i = VOICES - 1; i >= 0; i--)
                    if (vc_busy[i] && vc_chan[i] == ev.chan)
                        hit = i;
                if (hit < 0) begin
                    n_dropped++;
                    return 0;
                end
                n_steals++;
            end
            vc_busy[hit] = 1'b1;
            vc_key[hit]  = ev.key;
            vc_vel[hit]  = ev.lvl;
            vc_trk[hit]  = ev.trk;
            vc_chan[hit] = ev.chan;
        end
        w.voice  = hit[3:0];
        w.key_on = (op != sva_pkg::CMD_NOTE_OFF);
        w.freq   = NOTE_HZ[ev.key];
        w.level  = ev.lvl[6:3];
        return 1;
    endfunction

    function automatic void add_event(sva_pkg::t_cmd c, int ch, int trk, int key, int lvl);
        t_midi_event ev;
        ev.cmd  = c;
        ev.chan = ch[3:0];
        ev.trk  = trk[5:0];
        ev.key  = key[6:0];
        ev.lvl  = lvl[6:0];
        event_queue.push_back(ev);
    endfunction

    // mostly back to back, some short gaps, a few long ones, and stretches with no gaps
    function automatic int pick_gap(int sent);
        int r;
        if (((sent / 128) % 4) == 1)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk) begin : drive_proc
        t_note_word  w;
        t_midi_event nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                if (allocate_voice(drv_ev, w))
                    pending_words.push_back(w);
                n_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (event_queue.size() > 0) begin
                    nxt = event_queue.pop_front();
                    drv_ev   <= nxt;
                    in_valid <= 1'b1;
                    gap_left = pick_gap(n_sent);
                    n_sent++;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : stall_gen
        int r;
        static int run_left  = 0;
        static int hold_left = 0;
        static int n_cyc     = 0;
        n_cyc++;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (n_cyc == 2000 || n_cyc == 9000) begin
            // long hold-off so the allocator backs up into its input
            hold_left = 500;
            out_stall <= 1'b1;
        end else if (run_left > 0) begin
            run_left--;
        end else if (((n_cyc / 1024) % 4) == 2) begin
            out_stall <= 1'b0;
            run_left = 32;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                out_stall <= 1'b0;
                run_left = $urandom_range(0, 6);
            end else if (r < 95) begin
                out_stall <= 1'b1;
                run_left = $urandom_range(0, 3);
            end else begin
                out_stall <= 1'b1;
                run_left = $urandom_range(10, 40);
            end
        end
    end

    always @(posedge clk) begin : word_check
        t_note_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_words.size() == 0) begin
                $error("unexpected word: voice_index %0d key_on %0d", voice_index, key_on);
                n_err++;
            end else begin
                want = pending_words.pop_front();
                n_words++;
                if (want.key_on)
                    n_key_on++;
                if (voice_index !== want.voice) begin
                    $error("voice_index: expected %0d, got %0d", want.voice, voice_index);
                    n_err++;
                end
                if (key_on !== want.key_on) begin
                    $error("key_on: expected %0d, got %0d", want.key_on, key_on);
                    n_err++;
                end
                if (frequency_word !== want.freq) begin
                    $error("frequency_word: expected 0x%08h, got 0x%08h",
                           want.freq, frequency_word);
                    n_err++;
                end
                if (envelope_level !== want.level) begin
                    $error("envelope_level: expected %0d, got %0d",
                           want.level, envelope_level);
                    n_err++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("timeout after %0d cycles: %0d of %0d events taken, %0d words due",
                     cycle_count, n_accepted, n_sent, pending_words.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin : stim
        t_midi_event nt;
        t_midi_event held [$];
        int n;
        int k;
        int pick;
        int idx;
        int p;
        int total;

        // extremes, match and no-match paths
        add_event(sva_pkg::CMD_NOTE_ON,    0,  0,   0, 127);
        add_event(sva_pkg::CMD_NOTE_ON,   15, 63, 127,   1);
        add_event(sva_pkg::CMD_AFTERTOUCH, 0,  0,   0,  64);
        add_event(sva_pkg::CMD_AFTERTOUCH, 0,  0,   1,  64);
        add_event(sva_pkg::CMD_NOTE_ON,    0,  0,   0,   8);
        add_event(sva_pkg::CMD_NOTE_OFF,  15, 63, 127, 127);
        add_event(sva_pkg::CMD_NOTE_OFF,  15, 63, 127,   0);
        // drum channel and percussion programs block note on
        add_event(sva_pkg::CMD_NOTE_ON,    9,  5,  60, 100);
        add_event(sva_pkg::CMD_PROGRAM,    2,  0,   0,  15);
        add_event(sva_pkg::CMD_NOTE_ON,    2,  1,  60, 100);
        add_event(sva_pkg::CMD_PROGRAM,    2,  0,   0, 112);
        add_event(sva_pkg::CMD_NOTE_ON,    2,  1,  60, 100);
        add_event(sva_pkg::CMD_PROGRAM,    2,  0,   0,   7);
        add_event(sva_pkg::CMD_NOTE_ON,    2,  1,  60, 100);
        // velocity zero still releases under a percussion program
        add_event(sva_pkg::CMD_PROGRAM,    2,  0,   0, 119);
        add_event(sva_pkg::CMD_NOTE_ON,    2,  1,  60,   0);
        add_event(sva_pkg::CMD_PROGRAM,    2,  0,   0,   0);
        // fill every free voice, then steal one, then drop on an idle channel
        for (k = 0; k < 8; k++)
            add_event(sva_pkg::CMD_NOTE_ON, 1, 2, 40 + k, 16 + k * 12);
        add_event(sva_pkg::CMD_NOTE_ON,    1,  2,  50,  90);
        add_event(sva_pkg::CMD_NOTE_ON,    6,  3,  50,  90);

        // note on/aftertouch/release sequences with random content, plus noise
        for (n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(0, 99);
            if (held.size() == 0 && pick >= 12)
                pick = 20;
            if (pick < 6) begin
                add_event(sva_pkg::t_cmd'($urandom_range(0, 3)), $urandom_range(0, 15),
                          $urandom_range(0, 63), $urandom_range(0, 127),
                          $urandom_range(0, 127));
            end else if (pick < 12) begin
                if ($urandom_range(0, 3) == 0) begin
                    p = $urandom_range(0, 127);
                end else begin
                    do p = $urandom_range(0, 127); while (is_perc_program(p[6:0]));
                end
                add_event(sva_pkg::CMD_PROGRAM, $urandom_range(0, 15),
                          $urandom_range(0, 63), $urandom_range(0, 127), p);
            end else if (pick < 52) begin
                nt.cmd  = sva_pkg::CMD_NOTE_ON;
                nt.chan = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3))
                                                     : 4'($urandom_range(0, 15));
                nt.trk  = $urandom_range(0, 1) ? 6'($urandom_range(0, 3))
                                               : 6'($urandom_range(0, 63));
                nt.key  = 7'($urandom_range(0, 127));
                add_event(sva_pkg::CMD_NOTE_ON, int'(nt.chan), int'(nt.trk), int'(nt.key),
                          $urandom_range(1, 127));
                held.push_back(nt);
                if (held.size() > 20)
                    void'(held.pop_front());
            end else begin
                idx = $urandom_range(0, held.size() - 1);
                nt  = held[idx];
                if (pick < 58) begin
                    add_event(sva_pkg::CMD_NOTE_ON, int'(nt.chan), int'(nt.trk),
                              int'(nt.key), $urandom_range(1, 127));
                end else if (pick < 70) begin
                    add_event(sva_pkg::CMD_AFTERTOUCH, int'(nt.chan), int'(nt.trk),
                              int'(nt.key), $urandom_range(0, 127));
                end else begin
                    if ($urandom_range(0, 3) == 0)
                        add_event(sva_pkg::CMD_NOTE_ON, int'(nt.chan), int'(nt.trk),
                                  int'(nt.key), 0);
                    else
                        add_event(sva_pkg::CMD_NOTE_OFF, int'(nt.chan), int'(nt.trk),
                                  int'(nt.key), $urandom_range(0, 127));
                    held.delete(idx);
                end
            end
        end
        total = event_queue.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted < total)
            @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);

        $display("%0d MIDI events sent, %0d note words checked (%0d key-on) in %0d cycles",
                 n_accepted, n_words, n_key_on, cycle_count);
        $display("%0d voice steals, %0d note ons dropped, %0d drum/percussion skips",
                 n_steals, n_dropped, n_skipped);
        if (n_err == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
